/* sv/tlcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_pkg
// shared types, constants and functions of the telemetry line crc16 framer
// ----------------------------------------------------------------------------
package tlcf_pkg;

    localparam logic [15:0] CRC_SEED    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [3:0]  PREFIX_RST  = 4'd2;
    localparam logic [7:0]  CHAR_STAR   = 8'h2A;
    localparam logic [7:0]  CHAR_NL     = 8'h0A;
    localparam int          QUEUE_DEPTH = 4;

    // one accepted byte as handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        eol;
        logic [15:0] crc;
    } t_entry;

    // output sequencer phase
    typedef enum logic [2:0] {
        PH_DATA,
        PH_STAR,
        PH_HEX3,
        PH_HEX2,
        PH_HEX1,
        PH_HEX0,
        PH_NEWLINE
    } t_phase;

    // crc-16 ccitt-false, one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] ch;
        if (n < 4'd10) begin
            ch = 8'h30 + {4'h0, n};
        end else begin
            ch = 8'h37 + {4'h0, n};
        end
        return ch;
    endfunction

endpackage

/* sv/tlcf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_front
// holds the prefix register, counts the prefix and runs the crc per byte
// ----------------------------------------------------------------------------
module tlcf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_line,
    output tlcf_pkg::t_entry  o_entry
);

    logic [3:0]  r_prefix_skip;
    logic [3:0]  r_bytes_seen;
    logic [15:0] r_crc;
    logic [3:0]  n_bytes_seen;
    logic [15:0] n_crc;
    logic        in_prefix;

    assign in_prefix = (r_bytes_seen < r_prefix_skip);

    always_comb begin
        n_bytes_seen = r_bytes_seen;
        n_crc        = r_crc;
        if (in_prefix) begin
            n_bytes_seen = r_bytes_seen + 4'd1;
        end else begin
            n_crc = tlcf_pkg::crc_byte(r_crc, i_data_byte);
        end
    end

    // crc after this byte travels with it for the trailer
    assign o_entry.data = i_data_byte;
    assign o_entry.eol  = i_end_of_line;
    assign o_entry.crc  = n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_skip <= tlcf_pkg::PREFIX_RST;
            r_bytes_seen  <= '0;
            r_crc         <= tlcf_pkg::CRC_SEED;
        end else begin
            if (i_cfg_valid) begin
                r_prefix_skip <= i_cfg_data;
            end
            if (i_accept) begin
                if (i_end_of_line) begin
                    r_bytes_seen <= '0;
                    r_crc        <= tlcf_pkg::CRC_SEED;
                end else begin
                    r_bytes_seen <= n_bytes_seen;
                    r_crc        <= n_crc;
                end
            end
        end
    end

endmodule

/* sv/tlcf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_queue
// small fifo between front and back (depth a power of two, at least 2)
// ----------------------------------------------------------------------------
module tlcf_queue #(
    parameter int DEPTH = tlcf_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  tlcf_pkg::t_entry  i_entry,
    input  logic              i_rd,
    output tlcf_pkg::t_entry  o_entry,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tlcf_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CW'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* sv/tlcf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_back
// emits each queued byte and, after a line's last byte, the crc trailer
// ----------------------------------------------------------------------------
module tlcf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlcf_pkg::t_entry  i_entry,
    input  logic              i_q_empty,
    output logic              o_deq,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_last_out
);

    tlcf_pkg::t_phase r_phase;
    tlcf_pkg::t_phase n_phase;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [7:0]       n_byte;
    logic             n_last;
    logic             slot_free;
    logic             advance;

    assign slot_free = !r_valid || i_pop;
    assign advance   = slot_free && !i_q_empty;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (advance) begin
            unique case (r_phase)
                tlcf_pkg::PH_DATA:    n_phase = i_entry.eol ? tlcf_pkg::PH_STAR
                                                            : tlcf_pkg::PH_DATA;
                tlcf_pkg::PH_STAR:    n_phase = tlcf_pkg::PH_HEX3;
                tlcf_pkg::PH_HEX3:    n_phase = tlcf_pkg::PH_HEX2;
                tlcf_pkg::PH_HEX2:    n_phase = tlcf_pkg::PH_HEX1;
                tlcf_pkg::PH_HEX1:    n_phase = tlcf_pkg::PH_HEX0;
                tlcf_pkg::PH_HEX0:    n_phase = tlcf_pkg::PH_NEWLINE;
                tlcf_pkg::PH_NEWLINE: n_phase = tlcf_pkg::PH_DATA;
                default:              n_phase = tlcf_pkg::PH_DATA;
            endcase
        end
    end

    // character for the current phase
    always_comb begin
        n_last = 1'b0;
        o_deq  = 1'b0;
        unique case (r_phase)
            tlcf_pkg::PH_DATA: begin
                n_byte = i_entry.data;
                o_deq  = advance && !i_entry.eol;
            end
            tlcf_pkg::PH_STAR:    n_byte = tlcf_pkg::CHAR_STAR;
            tlcf_pkg::PH_HEX3:    n_byte = tlcf_pkg::hex_char(i_entry.crc[15:12]);
            tlcf_pkg::PH_HEX2:    n_byte = tlcf_pkg::hex_char(i_entry.crc[11:8]);
            tlcf_pkg::PH_HEX1:    n_byte = tlcf_pkg::hex_char(i_entry.crc[7:4]);
            tlcf_pkg::PH_HEX0:    n_byte = tlcf_pkg::hex_char(i_entry.crc[3:0]);
            tlcf_pkg::PH_NEWLINE: begin
                n_byte = tlcf_pkg::CHAR_NL;
                n_last = 1'b1;
                o_deq  = advance;
            end
            default:              n_byte = i_entry.data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlcf_pkg::PH_DATA;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_byte = r_byte;
    assign o_last_out = r_last;

endmodule

/* sv/telemetry_line_crc16_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_line_crc16_framer
// passes line bytes through and closes each line with a crc-16 trailer
// ----------------------------------------------------------------------------
// Bytes of a telemetry line are pushed one item per clock while full is low and
// come out unchanged, one item per clock while popped, through a queue-like
// result port. The first prefix_skip bytes of each line (2 after reset) are
// left out of a CRC-16 (poly 0x1021, seed 0xFFFF, msb first, no final xor);
// every later byte is folded in. After the byte flagged end_of_line the block
// appends '*', four upper-case hex digits of the crc and a newline, with
// last_out high on the newline. A line's last byte stays at the queue head
// until the trailer sequencer has emitted the newline. The crc is computed in
// the front at accept time, so a queue of QUEUE_DEPTH items lets input
// continue while a trailer drains; push is held off only when it fills.
// A prefix_skip write takes effect at once and does not restart the line.
// ----------------------------------------------------------------------------
module telemetry_line_crc16_framer #(
    parameter int QUEUE_DEPTH = tlcf_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data,
    // input item side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_line,
    // result item side
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_out
);

    tlcf_pkg::t_entry wr_entry;
    tlcf_pkg::t_entry rd_entry;
    logic             accept;
    logic             q_empty;
    logic             deq;

    // the register is always writable
    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // front: prefix count and crc update
    tlcf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_line (i_end_of_line),
        .o_entry       (wr_entry)
    );

    // decoupling queue
    tlcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_entry (wr_entry),
        .i_rd    (deq),
        .o_entry (rd_entry),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // back: byte and trailer sequencer with output register
    tlcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (rd_entry),
        .i_q_empty  (q_empty),
        .o_deq      (deq),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_last_out (o_last_out)
    );

endmodule

/* test/telemetry_line_crc16_framer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_line_crc16_framer_tb
// self-checking bench for the crc-16 telemetry line framer
// ----------------------------------------------------------------------------
// A short scripted part covers the following cases:
//   - lines that end inside the prefix
//   - the zero character
//   - the standard "123456789" check string under a zero prefix
//   - the largest prefix
//   - a prefix change in the middle of a line
// A random part then pushes about 200 characters, grouped in lines of random
// length, with the prefix rewritten between phases. An in-bench model of the
// framer predicts every output character, and each popped character is checked
// against the oldest prediction. The sender pushes in bursts with gaps. The
// receiver pops on a stall pattern that is redrawn whenever its age wraps.
// ----------------------------------------------------------------------------
module telemetry_line_crc16_framer_tb;

    localparam logic [15:0] CRC_START    = 16'hFFFF;
    localparam logic [15:0] CRC_GEN      = 16'h1021;
    localparam logic [7:0]  ASTERISK     = 8'h2A;
    localparam logic [7:0]  NEWLINE      = 8'h0A;
    localparam int          RANDOM_CHARS = 200;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          SETTLE       = 16;
    localparam int          MAX_PRINTED  = 40;

    // one step of the scripted part: a character to push or a prefix to write
    typedef enum logic {ROW_CHAR, ROW_PREFIX} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  value;
        logic        eol;
        logic        typed;     // trailer digits typed in below
        logic [15:0] crc;
    } t_script_row;

    // one character expected on the output side
    typedef struct packed {
        logic [7:0] ch;
        logic       closes;
    } t_framed_char;

    // dut ports, all inputs known from time zero
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data    = '0;
    logic       push          = 1'b0;
    logic       full;
    logic [7:0] i_data_byte   = '0;
    logic       i_end_of_line = 1'b0;
    logic       empty;
    logic       pop           = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_out;

    // bench copy of the framer state
    logic [15:0]  line_crc     = CRC_START;
    logic [3:0]   prefix_count = '0;
    logic [3:0]   prefix_len   = 4'd2;
    t_framed_char chars_due[$];

    // typed-in trailer riding along with the character being pushed
    logic        typed_line = 1'b0;
    logic [15:0] typed_crc  = '0;

    int items_sent     = 0;
    int items_accepted = 0;
    int chars_checked  = 0;
    int lines_closed   = 0;
    int prefix_writes  = 0;
    int mismatches     = 0;
    int cycles         = 0;
    int burst_left     = 0;

    // receiver stall pattern
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [5:0]  stall_age     = '0;

    telemetry_line_crc16_framer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_end_of_line(i_end_of_line),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_last_out   (o_last_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // crc-16 ccitt-false, one data bit at a time, msb first
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] in_char);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ in_char[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_GEN : 16'h0000);
        end
        return acc;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    function automatic t_script_row char_row(input logic [7:0] in_char, input logic eol,
                                             input logic typed = 1'b0,
                                             input logic [15:0] crc = 16'h0000);
        return '{ROW_CHAR, in_char, eol, typed, crc};
    endfunction

    function automatic t_script_row prefix_row(input logic [3:0] value);
        return '{ROW_PREFIX, {4'h0, value}, 1'b0, 1'b0, 16'h0000};
    endfunction

    // queue up the characters one accepted input causes, and step the state
    task automatic frame_input_char(input logic [7:0] in_char, input logic eol,
                                    input logic typed, input logic [15:0] tcrc);
        logic [15:0] trailer_crc;
        chars_due.push_back('{in_char, 1'b0});
        // prefix characters only count; the rest go into the crc
        if (prefix_count < prefix_len) begin
            prefix_count = prefix_count + 4'd1;
        end else begin
            line_crc = crc16_fold(line_crc, in_char);
        end
        if (eol) begin
            trailer_crc = typed ? tcrc : line_crc;
            chars_due.push_back('{ASTERISK, 1'b0});
            for (int k = 3; k >= 0; k--) begin
                chars_due.push_back('{hex_ascii(trailer_crc[4*k +: 4]), 1'b0});
            end
            chars_due.push_back('{NEWLINE, 1'b1});
            // line closed: re-arm, prefix length stays
            line_crc     = CRC_START;
            prefix_count = '0;
            lines_closed++;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // burst/gap pacing of the sender, called before every push
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // push one character and hold it until the block takes it
    task automatic send_char(input logic [7:0] in_char, input logic eol,
                             input logic typed, input logic [15:0] crc);
        pace_sender();
        push          <= 1'b1;
        i_data_byte   <= in_char;
        i_end_of_line <= eol;
        typed_line    <= typed;
        typed_crc     <= crc;
        items_sent++;
        @(posedge i_clk);
        while (!(push && !full)) @(posedge i_clk);
    endtask

    // stop pushing and wait until every pushed item is in and all output is out
    task automatic wait_drained();
        push <= 1'b0;
        while (items_accepted != items_sent || chars_due.size() != 0) @(posedge i_clk);
    endtask

    // prefix writes only happen with the block idle
    task automatic write_prefix(input logic [3:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // monitor: config writes, accepted inputs and popped outputs, all sampled at the edge
    always @(posedge i_clk) begin : monitor
        t_framed_char due;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                prefix_len = i_cfg_data;
                prefix_writes++;
            end
            if (push && !full) begin
                items_accepted++;
                frame_input_char(i_data_byte, i_end_of_line, typed_line, typed_crc);
            end
            if (pop && !empty) begin
                if (chars_due.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h popped with none expected",
                                              o_out_byte));
                end else begin
                    due = chars_due.pop_front();
                    chars_checked++;
                    if (o_out_byte !== due.ch) begin
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  o_out_byte, due.ch));
                    end
                    if (o_last_out !== due.closes) begin
                        report_mismatch($sformatf("last_out %b on 0x%02h, expected %b",
                                                  o_last_out, o_out_byte, due.closes));
                    end
                end
            end
        end
    end

    // receiver: pops on a 16-bit pattern, redrawn each time the stall age wraps to zero
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (stall_age == 6'd0) begin
                case ($urandom_range(3))
                    0: stall_pattern = 16'hFFFF;                              // no stalls
                    1: stall_pattern = 16'($urandom) | 16'h0001;
                    2: stall_pattern = 16'h0001;                              // long stalls
                    default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
                endcase
            end
            pop <= stall_pattern[stall_age[3:0]];
            stall_age = stall_age + 6'd1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("telemetry_line_crc16_framer_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_script_row script[$];
        int          line_left;
        int          phase_left;
        int          phase_no;
        int          random_sent;
        logic [3:0]  new_prefix;
        logic [7:0]  rand_char;

        // line ends inside the reset prefix of 2: trailer carries the seed
        script.push_back(char_row(8'h41, 1'b1, 1'b1, 16'hFFFF));
        // zero character past the prefix, extremes of the byte
        script.push_back(char_row(8'h00, 1'b0));
        script.push_back(char_row(8'hFF, 1'b0));
        script.push_back(char_row(8'h00, 1'b1));
        // zero prefix: the standard check string gives 0x29b1
        script.push_back(prefix_row(4'd0));
        for (int d = 1; d <= 9; d++) begin
            script.push_back(char_row(8'h30 + 8'(d), d == 9, d == 9, 16'h29B1));
        end
        script.push_back(char_row(8'h00, 1'b1));
        // largest prefix, one-character line reads FFFF
        script.push_back(prefix_row(4'd15));
        script.push_back(char_row(8'hFF, 1'b1, 1'b1, 16'hFFFF));
        // prefix shortened in the middle of a line
        script.push_back(prefix_row(4'd4));
        script.push_back(char_row(8'h80, 1'b0));
        script.push_back(char_row(8'h7F, 1'b0));
        script.push_back(char_row(8'h55, 1'b0));
        script.push_back(prefix_row(4'd1));
        script.push_back(char_row(8'hAA, 1'b1));

        // hold reset at the start, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_PREFIX) begin
                write_prefix(script[r].value[3:0]);
            end else begin
                send_char(script[r].value, script[r].eol, script[r].typed, script[r].crc);
            end
        end

        // random lines; phases may cut a line, so the prefix also changes mid-line
        line_left   = 0;
        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_CHARS) begin
            case (phase_no)
                0: new_prefix = 4'd15;
                1: new_prefix = 4'd0;
                default: new_prefix = 4'($urandom_range(15));
            endcase
            write_prefix(new_prefix);
            phase_left = $urandom_range(20, 50);
            while ((phase_left > 0 && random_sent < RANDOM_CHARS) ||
                   (random_sent >= RANDOM_CHARS && line_left != 0)) begin
                if (line_left == 0) begin
                    // mostly normal lines, some of 1 to 3 characters that can end inside the prefix
                    line_left = ($urandom_range(7) == 0) ? $urandom_range(1, 3)
                                                         : $urandom_range(4, 30);
                end
                rand_char = ($urandom_range(3) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(8'h20, 8'h7E));
                send_char(rand_char, line_left == 1, 1'b0, 16'h0000);
                line_left--;
                phase_left--;
                random_sent++;
            end
            phase_no++;
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (chars_due.size() != 0) begin
            report_mismatch($sformatf("%0d output chars never arrived", chars_due.size()));
        end

        $display("framed %0d input chars into %0d lines, %0d output chars checked",
                 items_accepted, lines_closed, chars_checked);
        $display("prefix rewritten %0d times, from 0 to 15 and in mid-line", prefix_writes);
        if (mismatches == 0) begin
            $display("telemetry_line_crc16_framer_tb: PASS");
        end else begin
            $display("telemetry_line_crc16_framer_tb: FAIL");
        end
        $finish;
    end

endmodule
